// ----- rtl/fva_pkg.sv -----
// fva_pkg: shared types, constants and codes for the face-to-vertex averaging block
// used by fva_vertex_mem, fva_divider and face_to_vertex_average; no dependencies
package fva_pkg;

  // store geometry
  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int SUM_W        = 48;
  localparam int CNT_W        = 16;
  localparam int VAL_W        = 32;
  localparam int IDX_W        = 16;
  localparam int VC_W         = 13;
  localparam int LIM_W        = 17;
  localparam int STEP_W       = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
  localparam logic [VC_W-1:0]  VCOUNT_RESET = VC_W'(4096);

  // stream payload widths
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 48;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // top-level sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_RDATA,
    S_DIV,
    S_FINISH
  } fsm_e;

  // divider states
  typedef enum logic [1:0] {
    D_IDLE,
    D_ADD,
    D_ITER,
    D_NEG
  } div_fsm_e;

  // one vertex entry
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } entry_t;

  // divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/fva_vertex_mem.sv -----
// fva_vertex_mem: per-vertex sum and count store, one write and one read port
// read data registered, write-first on same-address collision; uses fva_pkg
module fva_vertex_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [fva_pkg::ADDR_W-1:0] waddr_i,
  input  fva_pkg::entry_t            wdata_i,
  input  logic [fva_pkg::ADDR_W-1:0] raddr_i,
  output fva_pkg::entry_t            rdata_o
);

  fva_pkg::entry_t mem_q [fva_pkg::MAX_VERTICES];
  fva_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, new data forwarded when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fva_divider.sv -----
// fva_divider: serial restoring divider, signed sum over unsigned count,
// rounded to nearest with ties away from zero; one quotient bit per cycle; uses fva_pkg
module fva_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fva_pkg::div_req_t req_i,
  output fva_pkg::div_rsp_t rsp_o
);

  fva_pkg::div_fsm_e                state_q, state_d;
  logic                             neg_q, neg_d;
  logic [fva_pkg::CNT_W-1:0]        div_q, div_d;
  logic [fva_pkg::SUM_W-1:0]        nq_q, nq_d;
  logic [fva_pkg::CNT_W-1:0]        rem_q, rem_d;
  logic [fva_pkg::STEP_W-1:0]       step_q, step_d;
  logic                             done_q, done_d;
  logic signed [fva_pkg::VAL_W-1:0] quo_q, quo_d;

  logic [fva_pkg::CNT_W:0] shifted;
  logic                    ge;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fva_pkg::D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    div_q  <= div_d;
    nq_q   <= nq_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    quo_q  <= quo_d;
  end

  // one restoring step
  assign shifted = {rem_q, nq_q[fva_pkg::SUM_W-1]};
  assign ge      = (shifted >= {1'b0, div_q});

  // sequencer
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    div_d   = div_q;
    nq_d    = nq_q;
    rem_d   = rem_q;
    step_d  = step_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    case (state_q)
      fva_pkg::D_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.sum[fva_pkg::SUM_W-1];
          nq_d    = req_i.sum[fva_pkg::SUM_W-1] ? -req_i.sum : req_i.sum;
          div_d   = req_i.count;
          state_d = fva_pkg::D_ADD;
        end
      end
      fva_pkg::D_ADD: begin
        // add half the divisor for round to nearest
        nq_d    = nq_q + fva_pkg::SUM_W'(div_q >> 1);
        rem_d   = '0;
        step_d  = '0;
        state_d = fva_pkg::D_ITER;
      end
      fva_pkg::D_ITER: begin
        rem_d  = ge ? fva_pkg::CNT_W'(shifted - {1'b0, div_q})
                    : shifted[fva_pkg::CNT_W-1:0];
        nq_d   = {nq_q[fva_pkg::SUM_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == fva_pkg::STEP_W'(fva_pkg::SUM_W - 1)) begin
          state_d = fva_pkg::D_NEG;
        end
      end
      fva_pkg::D_NEG: begin
        quo_d   = neg_q ? -nq_q[fva_pkg::VAL_W-1:0] : nq_q[fva_pkg::VAL_W-1:0];
        done_d  = 1'b1;
        state_d = fva_pkg::D_IDLE;
      end
      default: begin
        state_d = fva_pkg::D_IDLE;
      end
    endcase
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/face_to_vertex_average.sv -----
// face_to_vertex_average: scatters per-triangle values onto vertices and reads averages
// Channels: s_axis carries one command per transaction, tuser holds cmd (0 accumulate
//   triangle, 1 read and clear one vertex); m_axis returns exactly one result each.
// Configuration: cfg_we_i writes vertex_count from cfg_wdata_i; indices at or above
//   min(vertex_count, 4096) are out of range. Write only while the block is idle.
// Sequencing: an accumulate does one read-modify-write per corner through the store's
//   write and read ports, with a repeated corner forwarded from the write port. A
//   read of a used vertex waits on the divider, which forms one quotient bit per
//   cycle over the 48-bit sum; a read of an empty vertex and an out-of-range
//   command skip the divider. One command is in work at a time; s_axis_tready_o is
//   high only between commands.
// Reset: vertex_count returns to 4096 and a clearing pass zeroes all 4096 store
//   entries, one per cycle, so s_axis_tready_o stays low until the pass ends.
// Stall: a finished result sits in the output register; the next command is
//   accepted meanwhile, and its result waits until the previous one is taken,
//   with s_axis_tready_o low until then.
// Depends on fva_pkg, fva_vertex_mem and fva_divider.
module face_to_vertex_average (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_we_i,
  input  logic [fva_pkg::VC_W-1:0]      cfg_wdata_i,
  // command stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: vertex_a[15:0], vertex_b[31:16], vertex_c[47:32], face_value[79:48],
  //        read_index[95:80]
  input  logic [fva_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: cmd[0]
  input  logic                          s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: average_value[31:0], use_count[47:32]
  output logic [fva_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                    m_axis_tuser_o
);

  fva_pkg::fsm_e state_q, state_d;

  logic [fva_pkg::VC_W-1:0]   vcount_q, vcount_d;
  logic [fva_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [1:0]                 corner_q, corner_d;

  // latched command
  logic [fva_pkg::ADDR_W-1:0]       va_q, vb_q, vtx_c_q, rd_idx_q;
  logic [fva_pkg::ADDR_W-1:0]       va_d, vb_d, vtx_c_d, rd_idx_d;
  logic signed [fva_pkg::VAL_W-1:0] face_q, face_d;

  // result under construction
  fva_pkg::status_e                 status_q, status_d;
  logic signed [fva_pkg::VAL_W-1:0] avg_q, avg_d;
  logic [fva_pkg::CNT_W-1:0]        cnt_out_q, cnt_out_d;

  // output register
  logic                             out_valid_q, out_valid_d;
  fva_pkg::status_e                 out_status_q, out_status_d;
  logic signed [fva_pkg::VAL_W-1:0] out_avg_q, out_avg_d;
  logic [fva_pkg::CNT_W-1:0]        out_cnt_q, out_cnt_d;

  // store and divider interfaces
  logic                       mem_we;
  logic [fva_pkg::ADDR_W-1:0] mem_waddr, mem_raddr, cur_addr;
  fva_pkg::entry_t            mem_wdata, mem_rdata;
  fva_pkg::div_req_t          div_req;
  fva_pkg::div_rsp_t          div_rsp;

  // input field decode
  logic [fva_pkg::IDX_W-1:0]        in_va, in_vb, in_vc, in_rd;
  logic signed [fva_pkg::VAL_W-1:0] in_face;
  logic [fva_pkg::LIM_W-1:0]        lim;
  logic                             in_acc, load_out, tri_ok, rd_ok;

  assign in_va   = s_axis_tdata_i[15:0];
  assign in_vb   = s_axis_tdata_i[31:16];
  assign in_vc   = s_axis_tdata_i[47:32];
  assign in_face = s_axis_tdata_i[79:48];
  assign in_rd   = s_axis_tdata_i[95:80];

  // effective vertex limit and range checks
  assign lim = (fva_pkg::LIM_W'(vcount_q) > fva_pkg::LIM_W'(fva_pkg::MAX_VERTICES))
             ? fva_pkg::LIM_W'(fva_pkg::MAX_VERTICES) : fva_pkg::LIM_W'(vcount_q);
  assign tri_ok = (fva_pkg::LIM_W'(in_va) < lim) && (fva_pkg::LIM_W'(in_vb) < lim)
               && (fva_pkg::LIM_W'(in_vc) < lim);
  assign rd_ok  = (fva_pkg::LIM_W'(in_rd) < lim);

  assign s_axis_tready_o = (state_q == fva_pkg::S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fva_pkg::S_CLEAR;
      vcount_q    <= fva_pkg::VCOUNT_RESET;
      clr_addr_q  <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      clr_addr_q  <= clr_addr_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    va_q         <= va_d;
    vb_q         <= vb_d;
    vtx_c_q      <= vtx_c_d;
    rd_idx_q     <= rd_idx_d;
    face_q       <= face_d;
    status_q     <= status_d;
    avg_q        <= avg_d;
    cnt_out_q    <= cnt_out_d;
    out_status_q <= out_status_d;
    out_avg_q    <= out_avg_d;
    out_cnt_q    <= out_cnt_d;
  end

  // corner being updated
  always_comb begin
    case (corner_q)
      2'd0:    cur_addr = va_q;
      2'd1:    cur_addr = vb_q;
      default: cur_addr = vtx_c_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    vcount_d   = cfg_we_i ? cfg_wdata_i : vcount_q;
    clr_addr_d = clr_addr_q;
    corner_d   = corner_q;
    va_d       = va_q;
    vb_d       = vb_q;
    vtx_c_d    = vtx_c_q;
    rd_idx_d   = rd_idx_q;
    face_d     = face_q;
    status_d   = status_q;
    avg_d      = avg_q;
    cnt_out_d  = cnt_out_q;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = '0;
    mem_raddr  = s_axis_tuser_i ? in_rd[fva_pkg::ADDR_W-1:0] : in_va[fva_pkg::ADDR_W-1:0];
    div_req    = '0;
    load_out   = 1'b0;
    case (state_q)
      fva_pkg::S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == {fva_pkg::ADDR_W{1'b1}}) begin
          state_d = fva_pkg::S_IDLE;
        end
      end
      fva_pkg::S_IDLE: begin
        if (in_acc) begin
          va_d      = in_va[fva_pkg::ADDR_W-1:0];
          vb_d      = in_vb[fva_pkg::ADDR_W-1:0];
          vtx_c_d   = in_vc[fva_pkg::ADDR_W-1:0];
          rd_idx_d  = in_rd[fva_pkg::ADDR_W-1:0];
          face_d    = in_face;
          status_d  = fva_pkg::ST_OK;
          avg_d     = '0;
          cnt_out_d = '0;
          corner_d  = '0;
          if (s_axis_tuser_i ? !rd_ok : !tri_ok) begin
            status_d = fva_pkg::ST_RANGE;
            state_d  = fva_pkg::S_FINISH;
          end else if (s_axis_tuser_i) begin
            state_d = fva_pkg::S_RDATA;
          end else begin
            state_d = fva_pkg::S_ACC;
          end
        end
      end
      fva_pkg::S_ACC: begin
        // update this corner, fetch the next one
        mem_raddr = (corner_q == 2'd0) ? vb_q : vtx_c_q;
        if (mem_rdata.count == fva_pkg::COUNT_LIMIT) begin
          status_d = fva_pkg::ST_SAT;
        end else begin
          mem_we          = 1'b1;
          mem_wdata.sum   = mem_rdata.sum
                          + {{(fva_pkg::SUM_W-fva_pkg::VAL_W){face_q[fva_pkg::VAL_W-1]}},
                             face_q};
          mem_wdata.count = mem_rdata.count + 1'b1;
        end
        corner_d = corner_q + 1'b1;
        if (corner_q == 2'd2) begin
          state_d = fva_pkg::S_FINISH;
        end
      end
      fva_pkg::S_RDATA: begin
        // report and clear the entry
        cnt_out_d = mem_rdata.count;
        mem_we    = 1'b1;
        mem_waddr = rd_idx_q;
        if (mem_rdata.count == fva_pkg::COUNT_LIMIT) begin
          status_d = fva_pkg::ST_SAT;
        end
        if (mem_rdata.count == '0) begin
          state_d = fva_pkg::S_FINISH;
        end else begin
          div_req.start = 1'b1;
          div_req.sum   = mem_rdata.sum;
          div_req.count = mem_rdata.count;
          state_d       = fva_pkg::S_DIV;
        end
      end
      fva_pkg::S_DIV: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quotient;
          state_d = fva_pkg::S_FINISH;
        end
      end
      fva_pkg::S_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = fva_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fva_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = (out_valid_q && !m_axis_tready_i) || load_out;
    out_status_d = load_out ? status_q : out_status_q;
    out_avg_d    = load_out ? avg_q : out_avg_q;
    out_cnt_d    = load_out ? cnt_out_q : out_cnt_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_avg_q};
  assign m_axis_tuser_o  = out_status_q;

  fva_vertex_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fva_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // a new result is only loaded out of the finish state
  a_load_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == fva_pkg::S_FINISH))
    else $error("result loaded outside finish state");

  // divider completes only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == fva_pkg::S_DIV))
    else $error("divider done while not waiting");

  // a read either finishes at once or waits on the divider
  a_rdata_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fva_pkg::S_RDATA) |=>
      (state_q == fva_pkg::S_DIV) || (state_q == fva_pkg::S_FINISH))
    else $error("bad transition after read data");

  // no command taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fva_pkg::S_CLEAR) |-> (!s_axis_tready_o && mem_we))
    else $error("clearing pass not exclusive");

  // accumulate sweeps exactly three corners
  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fva_pkg::S_ACC) |-> (corner_q != 2'd3))
    else $error("corner counter overrun");

endmodule
